// File: rtl/core/nfha_pkg.sv
// Package for the next-fit heap allocator: sizes, codes and payload types.
// No dependencies.
`timescale 1ns / 1ps
package nfha_pkg;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int ADDR_BITS    = 20;
    localparam int SLOT_W       = $clog2(MAX_BLOCKS);
    localparam int LINK_W       = SLOT_W + 1;
    localparam int SIZE_W       = ADDR_BITS + 1;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_BLOCKS);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_BITS-1:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] out_addr;
        logic [SIZE_W-1:0]    used_total;
    } rsp_t;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
        logic [LINK_W-1:0]    nxt;
        logic [LINK_W-1:0]    prv;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
endpackage

// File: rtl/core/nfha_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on nfha_pkg.
`timescale 1ns / 1ps
interface nfha_req_if;
    import nfha_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nfha_rsp_if;
    import nfha_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/next_fit_heap_allocator_top.sv
// Next-fit heap allocator: a free scans the table slot by slot and an allocate walks it entry
// by entry, both paced by the single read port of the block table RAM. One transaction at a
// time; the result sits in an output register and a new request is taken while it waits.
// Reset empties the table (valid bits cleared at once), nulls head and cursor, and sets
// heap_bytes to 1 MiB.
// Depends on nfha_pkg, nfha_if, nfha_ctrl.
`timescale 1ns / 1ps
module next_fit_heap_allocator_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [nfha_pkg::SIZE_W-1:0] cfg_wdata,
    nfha_req_if.sink                    in_ch,
    nfha_rsp_if.source                  out_ch
);
    import nfha_pkg::*;

    logic [SIZE_W-1:0] heap_reg;
    logic              busy, done;
    logic              rsp_ready;
    rsp_t              rsp;
    rsp_t              out_reg;
    logic              ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= SIZE_W'(1 << ADDR_BITS);
        end
        else if (cfg_we)
        begin
            heap_reg <= cfg_wdata;
        end
    end

    assign in_ch.ready = !busy;

    // Hold the controller until the previous result is taken.
    assign rsp_ready = !ovalid_reg || out_ch.ready;

    nfha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .heap_bytes (heap_reg),
        .start      (in_ch.valid && in_ch.ready),
        .req        (in_ch.data),
        .rsp_ready  (rsp_ready),
        .busy       (busy),
        .done       (done),
        .rsp        (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (done)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= rsp;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = out_reg;
endmodule

// File: rtl/core/nfha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module nfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/nfha_ctrl.sv
// Sequencer for allocate and free: walks the block table in RAM entry by entry.
// Depends on nfha_pkg and nfha_ram.
`timescale 1ns / 1ps
module nfha_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [nfha_pkg::SIZE_W-1:0]   heap_bytes,
    input  logic                          start,
    input  nfha_pkg::req_t                req,
    input  logic                          rsp_ready,
    output logic                          busy,
    output logic                          done,
    output nfha_pkg::rsp_t                rsp
);
    import nfha_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FSCAN = 4'd1;  // free: scan slots for address
    localparam logic [3:0] S_FCHK  = 4'd2;
    localparam logic [3:0] S_FPRV  = 4'd3;  // free: patch prev.nxt
    localparam logic [3:0] S_FPRVW = 4'd4;
    localparam logic [3:0] S_FNXT  = 4'd5;
    localparam logic [3:0] S_FNXTW = 4'd6;
    localparam logic [3:0] S_AWALK = 4'd7;  // alloc: read entry k
    localparam logic [3:0] S_ANXT  = 4'd8;  // alloc: read entry next of k
    localparam logic [3:0] S_AEVAL = 4'd9;
    localparam logic [3:0] S_APRVW = 4'd10; // write prev entry's nxt
    localparam logic [3:0] S_ANRD  = 4'd11; // read next entry
    localparam logic [3:0] S_ANW   = 4'd12;
    localparam logic [3:0] S_ANEW  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0]           state_reg, state_next;
    logic [MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [LINK_W-1:0]    first_reg, first_next;
    logic [LINK_W-1:0]    cursor_reg, cursor_next;
    logic [SIZE_W-1:0]    used_reg, used_next;
    req_t                 req_reg, req_next;
    logic [LINK_W-1:0]    k_reg, k_next;         // current walk entry / found slot
    logic [LINK_W-1:0]    steps_reg, steps_next;
    logic                 pass_reg, pass_next;   // second pass from head
    entry_t               ek_reg, ek_next;       // latched entry k
    logic [LINK_W-1:0]    slot_reg, slot_next;
    logic [1:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] oaddr_reg, oaddr_next;

    logic                 we;
    logic [SLOT_W-1:0]    waddr, raddr;
    entry_t               wdata, rdata;
    logic [ENTRY_W-1:0]   rdata_raw;

    nfha_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_tab (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );
    assign rdata = entry_t'(rdata_raw);

    function automatic logic live(input logic [LINK_W-1:0] l, input logic [MAX_BLOCKS-1:0] v);
        live = (l < NIL_LINK) && v[l[SLOT_W-1:0]];
    endfunction

    // Lowest free slot; NIL when full.
    logic [LINK_W-1:0] free_slot;
    always_comb
    begin
        free_slot = NIL_LINK;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = LINK_W'(i);
            end
        end
    end

    logic [SIZE_W:0] limit;
    logic [SIZE_W:0] need;
    logic [SIZE_W:0] endk;
    logic [SIZE_W:0] stopk;
    logic            fits;
    logic [SIZE_W:0] hdr_addr;

    always_comb
    begin
        limit = (heap_bytes > SIZE_W'(1 << ADDR_BITS)) ? (SIZE_W+1)'(1 << ADDR_BITS)
                                                        : {1'b0, heap_bytes};
        need  = {1'b0, req_reg.req_size} + (SIZE_W+1)'(HEADER_BYTES);
        endk  = {2'b00, ek_reg.start} + {1'b0, ek_reg.size};
        stopk = live(ek_reg.nxt, valid_reg) ? {2'b00, rdata.start} : limit;
        fits  = (stopk > endk) && ((stopk - endk) > need);
        hdr_addr = {2'b00, rdata.start} + (SIZE_W+1)'(HEADER_BYTES);
    end

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        first_next  = first_reg;
        cursor_next = cursor_reg;
        used_next   = used_reg;
        req_next    = req_reg;
        k_next      = k_reg;
        steps_next  = steps_reg;
        pass_next   = pass_reg;
        ek_next     = ek_reg;
        slot_next   = slot_reg;
        status_next = status_reg;
        oaddr_next  = oaddr_reg;
        we          = 1'b0;
        waddr       = k_reg[SLOT_W-1:0];
        wdata       = ek_reg;
        raddr       = k_reg[SLOT_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req;
                    status_next = ST_OK;
                    oaddr_next  = '0;
                    steps_next  = '0;
                    pass_next   = 1'b0;
                    k_next      = '0;
                    if (req.action == ACT_FREE)
                    begin
                        state_next = S_FSCAN;
                    end
                    else if (!live(first_reg, valid_reg))
                    begin
                        if ({1'b0, req.req_size} + (SIZE_W+1)'(HEADER_BYTES) > limit)
                        begin
                            status_next = ST_NOSPACE;
                            state_next  = S_DONE;
                        end
                        else if (free_slot == NIL_LINK)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            slot_next   = free_slot;
                            k_next      = NIL_LINK;
                            ek_next.start = '0;
                            ek_next.size  = '0;
                            ek_next.nxt   = NIL_LINK;
                            first_next  = free_slot;
                            state_next  = S_ANEW;
                        end
                    end
                    else
                    begin
                        if (!live(cursor_reg, valid_reg))
                        begin
                            cursor_next = first_reg;
                            k_next      = first_reg;
                        end
                        else
                        begin
                            k_next = cursor_reg;
                        end
                        state_next = S_AWALK;
                    end
                end
            end
            // Free: read each slot and compare the payload address of the valid ones.
            S_FSCAN:
            begin
                raddr      = k_reg[SLOT_W-1:0];
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (valid_reg[k_reg[SLOT_W-1:0]]
                    && hdr_addr == {2'b00, req_reg.block_addr})
                begin
                    ek_next = rdata;
                    if (!live(rdata.prv, valid_reg))
                    begin
                        ek_next.prv = NIL_LINK;
                    end
                    if (!live(rdata.nxt, valid_reg))
                    begin
                        ek_next.nxt = NIL_LINK;
                    end
                    state_next = S_FPRV;
                end
                else if (k_reg == LINK_W'(MAX_BLOCKS - 1))
                begin
                    status_next = ST_UNKNOWN;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_FSCAN;
                end
            end
            S_FPRV:
            begin
                if (k_reg == cursor_reg)
                begin
                    cursor_next = ek_reg.prv;
                end
                used_next = (used_reg >= ek_reg.size) ? used_reg - ek_reg.size : '0;
                valid_next[k_reg[SLOT_W-1:0]] = 1'b0;
                if (k_reg == first_reg)
                begin
                    first_next = ek_reg.nxt;
                    state_next = S_FNXT;
                end
                else if (ek_reg.prv != NIL_LINK)
                begin
                    raddr      = ek_reg.prv[SLOT_W-1:0];
                    state_next = S_FPRVW;
                end
                else
                begin
                    state_next = S_FNXT;
                end
            end
            S_FPRVW:
            begin
                we         = 1'b1;
                waddr      = ek_reg.prv[SLOT_W-1:0];
                wdata      = rdata;
                wdata.nxt  = ek_reg.nxt;
                state_next = S_FNXT;
            end
            S_FNXT:
            begin
                if (ek_reg.nxt != NIL_LINK)
                begin
                    raddr      = ek_reg.nxt[SLOT_W-1:0];
                    state_next = S_FNXTW;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FNXTW:
            begin
                we         = 1'b1;
                waddr      = ek_reg.nxt[SLOT_W-1:0];
                wdata      = rdata;
                wdata.prv  = ek_reg.prv;
                state_next = S_DONE;
            end
            // Alloc walk: fetch k, then its successor, then judge the gap.
            S_AWALK:
            begin
                raddr      = k_reg[SLOT_W-1:0];
                state_next = S_ANXT;
            end
            S_ANXT:
            begin
                ek_next    = rdata;
                raddr      = rdata.nxt[SLOT_W-1:0];
                state_next = S_AEVAL;
            end
            S_AEVAL:
            begin
                if (fits)
                begin
                    if (free_slot == NIL_LINK)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        slot_next  = free_slot;
                        state_next = S_APRVW;
                    end
                end
                else
                begin
                    k_next     = ek_reg.nxt;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_AWALK;
                    if (!pass_reg)
                    begin
                        if (!live(ek_reg.nxt, valid_reg)
                            || steps_reg == LINK_W'(MAX_BLOCKS - 1))
                        begin
                            pass_next  = 1'b1;
                            steps_next = '0;
                            k_next     = first_reg;
                            if (first_reg == cursor_reg)
                            begin
                                status_next = ST_NOSPACE;
                                state_next  = S_DONE;
                            end
                        end
                    end
                    else if (ek_reg.nxt == cursor_reg || !live(ek_reg.nxt, valid_reg)
                             || steps_reg == LINK_W'(MAX_BLOCKS - 1))
                    begin
                        status_next = ST_NOSPACE;
                        state_next  = S_DONE;
                    end
                end
            end
            S_APRVW:
            begin
                we         = 1'b1;
                waddr      = k_reg[SLOT_W-1:0];
                wdata      = ek_reg;
                wdata.nxt  = slot_reg;
                if (!live(ek_reg.nxt, valid_reg))
                begin
                    ek_next.nxt = NIL_LINK;
                    state_next  = S_ANEW;
                end
                else
                begin
                    raddr      = ek_reg.nxt[SLOT_W-1:0];
                    state_next = S_ANRD;
                end
            end
            S_ANRD:
            begin
                // hold the read address so the next entry is still on rdata
                raddr      = ek_reg.nxt[SLOT_W-1:0];
                state_next = S_ANW;
            end
            S_ANW:
            begin
                we         = 1'b1;
                waddr      = ek_reg.nxt[SLOT_W-1:0];
                wdata      = rdata;
                wdata.prv  = slot_reg;
                state_next = S_ANEW;
            end
            S_ANEW:
            begin
                we          = 1'b1;
                waddr       = slot_reg[SLOT_W-1:0];
                wdata.start = ADDR_BITS'(endk);
                wdata.size  = SIZE_W'(need);
                wdata.nxt   = ek_reg.nxt;
                wdata.prv   = k_reg;
                valid_next[slot_reg[SLOT_W-1:0]] = 1'b1;
                cursor_next = slot_reg;
                used_next   = used_reg + SIZE_W'(need);
                oaddr_next  = ADDR_BITS'(endk + (SIZE_W+1)'(HEADER_BYTES));
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register can take it
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            first_reg  <= NIL_LINK;
            cursor_reg <= NIL_LINK;
            used_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            first_reg  <= first_next;
            cursor_reg <= cursor_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        k_reg      <= k_next;
        steps_reg  <= steps_next;
        pass_reg   <= pass_next;
        ek_reg     <= ek_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        oaddr_reg  <= oaddr_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = (state_reg == S_DONE) && rsp_ready;
    assign rsp.status      = status_reg;
    assign rsp.out_addr    = oaddr_reg;
    assign rsp.used_total  = used_reg;
endmodule

// File: bench/testbench.sv
// Testbench for the next-fit heap allocator: directed and random allocate/free traffic,
// heap size changes, backpressure, with a built-in predictor of the block table.
// Depends on nfha_pkg, nfha_if and next_fit_heap_allocator_top.
`timescale 1ns / 1ps
module testbench;
    import nfha_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS = 420;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    nfha_req_if in_ch();
    nfha_rsp_if out_ch();

    next_fit_heap_allocator_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always #1 clk = ~clk;

    // Predictor state: block table, head, cursor, byte count and heap size.
    logic [ADDR_BITS-1:0] tbl_start [MAX_BLOCKS];
    logic [SIZE_W-1:0] tbl_size [MAX_BLOCKS];
    int tbl_next [MAX_BLOCKS];
    int tbl_prev [MAX_BLOCKS];
    bit tbl_live [MAX_BLOCKS];
    int head_blk;
    int cursor_blk;
    logic [SIZE_W-1:0] bytes_in_use;
    logic [SIZE_W-1:0] heap_size;

    rsp_t expected_rsp[$];
    int errors = 0;
    int sent_count = 0;
    int checked_count = 0;
    int status_seen [4];
    bit hold_off_req = 1'b0;
    int rx_mode = 0;
    int burst_left = 0;

    function automatic bit slot_live(int k);
        return k >= 0 && k < MAX_BLOCKS && tbl_live[k];
    endfunction

    function automatic longint heap_end();
        longint lim;
        lim = longint'(1) << ADDR_BITS;
        return (longint'(heap_size) > lim) ? lim : longint'(heap_size);
    endfunction

    function automatic bit gap_after_fits(int k, longint need);
        longint blk_end;
        longint stop;
        blk_end = longint'(tbl_start[k]) + longint'(tbl_size[k]);
        stop = slot_live(tbl_next[k]) ? longint'(tbl_start[tbl_next[k]]) : heap_end();
        if (stop <= blk_end)
            return 1'b0;
        return (stop - blk_end) > need;
    endfunction

    function automatic int search_gap(longint need);
        int k;
        int steps;
        if (!slot_live(cursor_blk))
            cursor_blk = head_blk;
        k = cursor_blk;
        steps = 0;
        while (slot_live(k) && steps < MAX_BLOCKS)
        begin
            if (gap_after_fits(k, need))
                return k;
            k = tbl_next[k];
            steps++;
        end
        k = head_blk;
        steps = 0;
        while (k != cursor_blk && slot_live(k) && steps < MAX_BLOCKS)
        begin
            if (gap_after_fits(k, need))
                return k;
            k = tbl_next[k];
            steps++;
        end
        return MAX_BLOCKS;
    endfunction

    function automatic int first_empty_slot();
        for (int i = 0; i < MAX_BLOCKS; i++)
            if (!tbl_live[i])
                return i;
        return MAX_BLOCKS;
    endfunction

    function automatic rsp_t predict_alloc(logic [SIZE_W-1:0] req);
        rsp_t r;
        longint need;
        longint start;
        int slot;
        int prv;
        int nxt;
        r = '0;
        need = longint'(req) + HEADER_BYTES;
        if (!slot_live(head_blk))
        begin
            if (need > heap_end())
            begin
                r.status = ST_NOSPACE;
                r.used_total = bytes_in_use;
                return r;
            end
            slot = first_empty_slot();
            start = 0;
            prv = MAX_BLOCKS;
            nxt = MAX_BLOCKS;
            head_blk = slot;
        end
        else
        begin
            prv = search_gap(need);
            if (prv == MAX_BLOCKS)
            begin
                r.status = ST_NOSPACE;
                r.used_total = bytes_in_use;
                return r;
            end
            slot = first_empty_slot();
            if (slot == MAX_BLOCKS)
            begin
                r.status = ST_FULL;
                r.used_total = bytes_in_use;
                return r;
            end
            start = longint'(tbl_start[prv]) + longint'(tbl_size[prv]);
            nxt = tbl_next[prv];
            tbl_next[prv] = slot;
            if (slot_live(nxt))
                tbl_prev[nxt] = slot;
            else
                nxt = MAX_BLOCKS;
        end
        tbl_start[slot] = start[ADDR_BITS-1:0];
        tbl_size[slot] = need[SIZE_W-1:0];
        tbl_next[slot] = nxt;
        tbl_prev[slot] = prv;
        tbl_live[slot] = 1'b1;
        cursor_blk = slot;
        bytes_in_use = bytes_in_use + need[SIZE_W-1:0];
        need = start + HEADER_BYTES;
        r.status = ST_OK;
        r.out_addr = need[ADDR_BITS-1:0];
        r.used_total = bytes_in_use;
        return r;
    endfunction

    function automatic rsp_t predict_free(logic [ADDR_BITS-1:0] addr);
        rsp_t r;
        int k;
        int prv;
        int nxt;
        r = '0;
        k = MAX_BLOCKS;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            if (tbl_live[i] && longint'(tbl_start[i]) + HEADER_BYTES == longint'(addr))
            begin
                k = i;
                break;
            end
        end
        if (k == MAX_BLOCKS)
        begin
            r.status = ST_UNKNOWN;
            r.used_total = bytes_in_use;
            return r;
        end
        prv = slot_live(tbl_prev[k]) ? tbl_prev[k] : MAX_BLOCKS;
        nxt = slot_live(tbl_next[k]) ? tbl_next[k] : MAX_BLOCKS;
        if (k == cursor_blk)
            cursor_blk = prv;
        if (k == head_blk)
            head_blk = nxt;
        else if (prv != MAX_BLOCKS)
            tbl_next[prv] = nxt;
        if (nxt != MAX_BLOCKS)
            tbl_prev[nxt] = prv;
        bytes_in_use = (bytes_in_use >= tbl_size[k]) ? bytes_in_use - tbl_size[k] : '0;
        tbl_live[k] = 1'b0;
        r.status = ST_OK;
        r.used_total = bytes_in_use;
        return r;
    endfunction

    // Payload offset of a random live block, or a random offset if the table is empty.
    function automatic logic [ADDR_BITS-1:0] live_payload_addr();
        int picks[$];
        for (int i = 0; i < MAX_BLOCKS; i++)
            if (tbl_live[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return ADDR_BITS'($urandom);
        return ADDR_BITS'(tbl_start[picks[$urandom_range(picks.size() - 1)]] + HEADER_BYTES);
    endfunction

    task automatic send_item(logic act, logic [SIZE_W-1:0] sz, logic [ADDR_BITS-1:0] addr);
        rsp_t r;
        if (burst_left == 0)
        begin
            // valid is already low here; idle for a random gap
            @(negedge clk);
            repeat ($urandom_range(12)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        else
            @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= '{action: act, req_size: sz, block_addr: addr};
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
        if (act == ACT_ALLOC)
            r = predict_alloc(sz);
        else
            r = predict_free(addr);
        expected_rsp.push_back(r);
        sent_count++;
        // drop valid right away only when the burst ends; otherwise the next call reasserts
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    task automatic wait_drain();
        // end any open burst so the last transaction is not offered again
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_heap_size(logic [SIZE_W-1:0] value);
        wait_drain();
        // let the controller return to idle
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        heap_size = value;
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send_item(ACT_ALLOC, SIZE_W'($urandom_range(3000)), ADDR_BITS'($urandom));
        else if (pick < 52)
            send_item(ACT_ALLOC, SIZE_W'($urandom), ADDR_BITS'($urandom));
        else if (pick < 85)
            send_item(ACT_FREE, SIZE_W'($urandom), live_payload_addr());
        else if (pick < 93)
            send_item(ACT_FREE, SIZE_W'($urandom),
                      live_payload_addr() ^ ADDR_BITS'(1 << $urandom_range(4)));
        else
            send_item(ACT_FREE, SIZE_W'($urandom), ADDR_BITS'($urandom));
    endtask

    task automatic free_everything();
        for (int i = 0; i < MAX_BLOCKS; i++)
            if (tbl_live[i])
                send_item(ACT_FREE, '0, ADDR_BITS'(tbl_start[i] + HEADER_BYTES));
    endtask

    task automatic test_directed();
        logic [ADDR_BITS-1:0] a0;
        send_item(ACT_FREE, '0, '0);                       // free on empty table
        send_item(ACT_ALLOC, SIZE_W'(1 << ADDR_BITS), '0); // too large for heap
        send_item(ACT_ALLOC, '1, '1);                      // all ones request
        send_item(ACT_ALLOC, '0, '0);
        a0 = live_payload_addr();
        send_item(ACT_ALLOC, SIZE_W'(100), '0);
        send_item(ACT_ALLOC, SIZE_W'(5000), '0);
        send_item(ACT_FREE, '0, a0 + ADDR_BITS'(1));       // near miss
        send_item(ACT_FREE, '0, a0);
        send_item(ACT_FREE, '0, a0);                       // double free
        send_item(ACT_ALLOC, SIZE_W'(0), '0);
        send_item(ACT_ALLOC, SIZE_W'((1 << ADDR_BITS) - 8000), '0);
        send_item(ACT_FREE, '1, '1);
        free_everything();
        // exact fit of an empty heap, then one byte over
        send_item(ACT_ALLOC, SIZE_W'((1 << ADDR_BITS) - HEADER_BYTES), '0);
        free_everything();
        send_item(ACT_ALLOC, SIZE_W'((1 << ADDR_BITS) - HEADER_BYTES + 1), '0);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < MAX_BLOCKS + 2; i++)
            send_item(ACT_ALLOC, SIZE_W'($urandom_range(40)), '0);
        // open a hole in the middle and refill it past the cursor
        send_item(ACT_FREE, '0, ADDR_BITS'(tbl_start[5] + HEADER_BYTES));
        send_item(ACT_ALLOC, '0, '0);
        send_item(ACT_ALLOC, '0, '0);
        free_everything();
    endtask

    task automatic test_heap_config();
        write_heap_size('0);
        send_item(ACT_ALLOC, '0, '0);
        write_heap_size(SIZE_W'(4096));
        repeat (40) random_item();
        write_heap_size(SIZE_W'(100));                     // shrink below live blocks
        repeat (20) random_item();
        write_heap_size('1);                               // above range, clamps
        repeat (40) random_item();
        write_heap_size(SIZE_W'($urandom_range(200, 20000)));
        repeat (40) random_item();
        free_everything();
        write_heap_size(SIZE_W'(1 << ADDR_BITS));
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (30) random_item();
        wait_drain();                                      // sender pause until all results are back
        repeat ($urandom_range(5, 40)) @(posedge clk);
        repeat (30) random_item();
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                rx_mode = $urandom_range(2);
            random_item();
        end
    endtask

    // Receiver: stall pattern by mode, plus one long hold-off on request.
    always @(negedge clk)
    begin
        int hold_cnt;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_cnt = 0;
        end
        else if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            hold_cnt = 400;
            out_ch.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end
        else if (rx_mode == 0)
            out_ch.ready <= 1'b1;
        else if (rx_mode == 1)
            out_ch.ready <= ($urandom_range(3) != 0);
        else
            out_ch.ready <= ($urandom_range(7) < 2);
    end

    always @(posedge clk)
    begin
        rsp_t exp_r;
        rsp_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result transaction: %p", got);
                errors++;
            end
            else
            begin
                exp_r = expected_rsp.pop_front();
                checked_count++;
                status_seen[exp_r.status]++;
                if (got.status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.out_addr !== exp_r.out_addr)
                begin
                    $error("out_addr: expected %0d, actual %0d", exp_r.out_addr, got.out_addr);
                    errors++;
                end
                if (got.used_total !== exp_r.used_total)
                begin
                    $error("used_total: expected %0d, actual %0d",
                           exp_r.used_total, got.used_total);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        int idle_cycles;
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            tbl_start[i] = '0;
            tbl_size[i] = '0;
            tbl_next[i] = 0;
            tbl_prev[i] = 0;
            tbl_live[i] = 1'b0;
        end
        head_blk = MAX_BLOCKS;
        cursor_blk = MAX_BLOCKS;
        bytes_in_use = '0;
        heap_size = SIZE_W'(1 << ADDR_BITS);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_heap_config();
        test_backpressure();
        test_random();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d requests, checked %0d results over several heap sizes.",
                 sent_count, checked_count);
        $display("Status counts: ok %0d, no space %0d, table full %0d, unknown %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/nfha_pkg.sv
rtl/core/nfha_if.sv
rtl/core/nfha_ram.sv
rtl/core/nfha_ctrl.sv
rtl/core/next_fit_heap_allocator_top.sv
bench/testbench.sv
